// ===== src/akrt_pkg.sv =====
package akrt_pkg;

  // per-key press phase
  typedef enum logic [1:0] {
    PH_REG_REL = 2'd0,
    PH_REG_PRS = 2'd1,
    PH_RPD_REL = 2'd2,
    PH_RPD_PRS = 2'd3
  } phase_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_CAL,
    S_ADV
  } seq_state_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KEY_MODE       = 3'd0,
    CFG_ACTUATION      = 3'd1,
    CFG_HYSTERESIS     = 3'd2,
    CFG_SENSITIVITY    = 3'd3,
    CFG_ZERO_JITTER    = 3'd4,
    CFG_FULL_JITTER    = 3'd5,
    CFG_RELEASE_SETTLE = 3'd6,
    CFG_BOTTOM_ZONE    = 3'd7
  } cfg_index_e;

  // travel margin added before comparing against the bottom zone
  localparam logic [8:0] BOTTOM_MARGIN = 9'd10;

  // stream widths
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned QUOT_W     = 8;

endpackage

// ===== src/akrt_div.sv =====
module akrt_div import akrt_pkg::*; #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ADC_BITS+QUOT_W-1:0] dividend_i,
  input  logic [ADC_BITS-1:0]        divisor_i,
  output logic                       done_o,
  output logic [QUOT_W-1:0]          quotient_o
);

  logic                busy_q, busy_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [ADC_BITS-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0]   lo_q, lo_d;
  logic [ADC_BITS-1:0] dvs_q, dvs_d;
  logic [ADC_BITS:0]   cand;
  logic [ADC_BITS:0]   diff;

  // one quotient bit per cycle, restoring form
  always_comb begin
    cand   = {rem_q, lo_q[QUOT_W-1]};
    diff   = cand - {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i[ADC_BITS+QUOT_W-1:QUOT_W];
      lo_d   = dividend_i[QUOT_W-1:0];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (cand >= {1'b0, dvs_q}) begin
        rem_d = diff[ADC_BITS-1:0];
        lo_d  = {lo_q[QUOT_W-2:0], 1'b1};
      end else begin
        rem_d = cand[ADC_BITS-1:0];
        lo_d  = {lo_q[QUOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = busy_q && !busy_d;
  assign quotient_o = lo_d;

endmodule

// ===== src/analog_key_rapid_trigger_core.sv =====
// sequence: a key in range passes multiply, divide, calibrate and advance; an out of range key goes
// straight to advance; the divide step uses the 8-step bit-serial divider
// the input is not ready while a sample is in work; a finished result waits in the output
// register and the next sample is taken meanwhile, a full output register stalls the last step
// reset: asynchronous active low, registers to defaults, per-key valid bits cleared
// at once so every key reads its default state, no clearing pass
module analog_key_rapid_trigger_core import akrt_pkg::*; #(
  parameter int unsigned KEY_COUNT       = 128,
  parameter int unsigned ADC_BITS        = 12,
  parameter int unsigned DEFAULT_REST    = 3000,
  parameter int unsigned DEFAULT_RANGE   = 1000,
  parameter int unsigned TRAVEL_MAX      = 240,
  parameter int unsigned PRESS_SETTLE_MS = 100
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // key_index[6:0], adc_sample[18:7], time_ms[50:19]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_key_index[6:0], travel[14:7], key_down[15], changed[16], calibrated[17]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_addr_i,
  input  logic [15:0]           cfg_data_i
);

  localparam int unsigned AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned AB = ADC_BITS;
  localparam logic [AB-1:0] ADC_MASK = AB'((32'd1 << AB) - 32'd1);
  localparam logic [AB-1:0] DEF_REST = AB'(DEFAULT_REST) & ADC_MASK;
  localparam logic [AB-1:0] DEF_BOT  = (DEFAULT_REST < DEFAULT_RANGE) ? '0 :
                                       AB'(DEFAULT_REST - DEFAULT_RANGE) & ADC_MASK;
  localparam logic [7:0]  FT        = 8'(TRAVEL_MAX);
  localparam logic [31:0] PRESS_SET = 32'(PRESS_SETTLE_MS);

  typedef struct packed {
    phase_e        phase;
    logic [8:0]    pp;
    logic [7:0]    rp;
    logic          cal;
    logic          sf;
    logic          bf;
    logic [31:0]   ss;
    logic [31:0]   bs;
    logic [AB-1:0] prev;
    logic [AB-1:0] rest;
    logic [AB-1:0] bot;
  } key_word_t;

  localparam key_word_t RST_WORD = '{phase: PH_REG_REL, pp: '0, rp: '0, cal: 1'b0,
                                     sf: 1'b0, bf: 1'b0, ss: '0, bs: '0, prev: '0,
                                     rest: DEF_REST, bot: DEF_BOT};

  // configuration registers
  logic        mode_q;
  logic [7:0]  act_q, hyst_q, sens_q, bz_q;
  logic [11:0] zj_q, fj_q;
  logic [15:0] rsm_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      act_q  <= 8'd120;
      hyst_q <= 8'd30;
      sens_q <= 8'd18;
      zj_q   <= 12'd50;
      fj_q   <= 12'd100;
      rsm_q  <= 16'd500;
      bz_q   <= 8'd228;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_addr_i))
        CFG_KEY_MODE:       mode_q <= cfg_data_i[0];
        CFG_ACTUATION:      act_q  <= cfg_data_i[7:0];
        CFG_HYSTERESIS:     hyst_q <= cfg_data_i[7:0];
        CFG_SENSITIVITY:    sens_q <= cfg_data_i[7:0];
        CFG_ZERO_JITTER:    zj_q   <= cfg_data_i[11:0];
        CFG_FULL_JITTER:    fj_q   <= cfg_data_i[11:0];
        CFG_RELEASE_SETTLE: rsm_q  <= cfg_data_i;
        CFG_BOTTOM_ZONE:    bz_q   <= cfg_data_i[7:0];
        default:            mode_q <= mode_q;
      endcase
    end
  end

  // input fields
  logic [6:0]     in_idx;
  logic [AB+11:0] in_adc_ext;
  logic [AW+6:0]  in_idx_ext;
  assign in_idx     = s_axis_tdata[6:0];
  assign in_adc_ext = (AB+12)'(s_axis_tdata[18:7]);
  assign in_idx_ext = (AW+7)'(in_idx);

  seq_state_e state_q, state_d;
  logic          in_xfer;
  logic [6:0]    idx_q;
  logic [AW-1:0] addr_q;
  logic [AB-1:0] raw_q;
  logic [31:0]   now_q;
  logic          oor_q;
  logic          hit_q;
  key_word_t     rd_q, st_q, st_d, cur;
  logic [7:0]    trav_q, trav_d;
  logic          zero_q;
  logic [KEY_COUNT-1:0] vld_q;
  key_word_t     mem [KEY_COUNT];

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // sample capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      idx_q  <= in_idx;
      addr_q <= in_idx_ext[AW-1:0];
      raw_q  <= in_adc_ext[AB-1:0];
      now_q  <= s_axis_tdata[50:19];
      oor_q  <= (9'(in_idx) >= 9'(KEY_COUNT));
    end
  end

  // key state memory, registered read
  logic mem_we;
  always_ff @(posedge clk_i) begin
    if (in_xfer) rd_q <= mem[in_idx_ext[AW-1:0]];
    if (mem_we) mem[addr_q] <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (in_xfer) hit_q <= (9'(in_idx) < 9'(KEY_COUNT)) && vld_q[in_idx_ext[AW-1:0]];
      if (mem_we) vld_q[addr_q] <= 1'b1;
    end
  end

  assign cur = hit_q ? rd_q : RST_WORD;

  // travel set-up: clamp and scale
  logic [AB-1:0]    top, bot, rawc, press_amt, span;
  logic [AB+7:0]    product;
  logic             div_start, div_done;
  logic [QUOT_W-1:0] quot;
  always_comb begin
    top       = cur.cal ? cur.rest : DEF_REST;
    bot       = cur.cal ? cur.bot  : DEF_BOT;
    rawc      = (raw_q > top) ? top : ((raw_q < bot) ? bot : raw_q);
    press_amt = top - rawc;
    span      = top - bot;
    product   = (AB+8)'(press_amt) * (AB+8)'(FT);
  end

  akrt_div #(.ADC_BITS(AB)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (span),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // calibration step
  key_word_t  cw;
  logic [AB-1:0] d_prev, d_rest, d_bot;
  logic       stable_now, bot_cond;
  always_comb begin
    cw         = st_q;
    d_prev     = (raw_q > st_q.prev) ? raw_q - st_q.prev : st_q.prev - raw_q;
    d_rest     = (raw_q > st_q.rest) ? raw_q - st_q.rest : st_q.rest - raw_q;
    d_bot      = (raw_q > st_q.bot)  ? raw_q - st_q.bot  : st_q.bot  - raw_q;
    stable_now = 17'(d_prev) < 17'(zj_q);
    cw.sf      = stable_now;
    if (stable_now && !st_q.sf) cw.ss = now_q;
    if (cw.sf && !st_q.bf && ((now_q - cw.ss) > 32'(rsm_q))) begin
      if (!st_q.cal || (17'(d_rest) > 17'(zj_q))) cw.rest = raw_q;
    end
    bot_cond = (9'(trav_q) + BOTTOM_MARGIN) > 9'(bz_q);
    cw.bf    = bot_cond;
    if (bot_cond) begin
      if (!st_q.bf) cw.bs = now_q;
      if (((now_q - cw.bs) > PRESS_SET) && cw.sf) begin
        if (!st_q.cal || (17'(d_bot) > 17'(fj_q))) begin
          cw.bot = raw_q;
          cw.cal = 1'b1;
        end
      end
    end
    cw.prev = raw_q;
  end

  // phase step
  key_word_t  aw;
  logic [7:0] rel, t, pr_rp;
  logic [8:0] rl_pp;
  logic       achg;
  always_comb begin
    aw    = st_q;
    achg  = 1'b0;
    t     = trav_q;
    rel   = (act_q > hyst_q) ? act_q - hyst_q : 8'd0;
    pr_rp = (t > sens_q) ? t - sens_q : 8'd0;
    rl_pp = 9'(t) + 9'(sens_q);
    case (st_q.phase)
      PH_REG_REL: begin
        if (t >= act_q) begin
          aw.phase = PH_REG_PRS;
          achg     = 1'b1;
          if (mode_q) begin
            aw.rp = pr_rp;
            aw.pp = 9'(t);
          end
        end
      end
      default: begin
        if (!mode_q) begin
          if (st_q.phase == PH_REG_PRS && t <= rel) begin
            aw.phase = PH_REG_REL;
            achg     = 1'b1;
          end
        end else if (st_q.phase == PH_RPD_REL) begin
          if (t <= rel) begin
            aw.phase = PH_REG_REL;
          end else if (9'(t) >= st_q.pp && t >= act_q) begin
            aw.phase = PH_RPD_PRS;
            achg     = 1'b1;
            aw.rp    = pr_rp;
            aw.pp    = 9'(t);
          end else if (t < st_q.rp) begin
            aw.rp = t;
            aw.pp = rl_pp;
          end
        end else begin
          if (t <= rel) begin
            aw.phase = PH_REG_REL;
            achg     = 1'b1;
          end else if (t <= st_q.rp && (rl_pp < 9'(bz_q))) begin
            aw.phase = PH_RPD_REL;
            achg     = 1'b1;
            aw.rp    = t;
            aw.pp    = rl_pp;
          end else if (9'(t) > st_q.pp) begin
            aw.rp = pr_rp;
            aw.pp = 9'(t);
          end
        end
      end
    endcase
  end

  // sequencer
  logic out_free, fire;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    st_d          = st_q;
    trav_d        = trav_q;
    div_start     = 1'b0;
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    fire          = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = (9'(in_idx) >= 9'(KEY_COUNT)) ? S_ADV : S_MUL;
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        st_d      = cur;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          trav_d  = zero_q ? 8'd0 : ((quot > FT) ? FT : quot);
          state_d = S_CAL;
        end
      end
      S_CAL: begin
        st_d    = cw;
        state_d = S_ADV;
      end
      S_ADV: begin
        // phase step is taken once, when the result can leave
        if (out_free) begin
          st_d    = aw;
          fire    = 1'b1;
          mem_we  = !oor_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    trav_q <= trav_d;
    if (state_q == S_MUL) zero_q <= (bot >= top);
  end

  // output register
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  kd;
  assign kd = (aw.phase == PH_REG_PRS) || (aw.phase == PH_RPD_PRS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            m_valid_q <= 1'b0;
    else if (fire)          m_valid_q <= 1'b1;
    else if (m_axis_tready) m_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (oor_q) m_data_q <= OUT_DATA_W'(idx_q);
      else       m_data_q <= OUT_DATA_W'({aw.cal, achg, kd, trav_q, idx_q});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== src/akrt_chk.sv =====
module akrt_chk import akrt_pkg::*; #(
  parameter int unsigned KEY_COUNT  = 128,
  parameter int unsigned TRAVEL_MAX = 240
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one sample in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sample taken while busy");

  // travel stays within full scale
  a_travel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[14:7]) <= TRAVEL_MAX)
    else $error("travel out of range");

  // out of range keys report nothing
  a_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (32'(m_axis_tdata[6:0]) >= KEY_COUNT) |->
      m_axis_tdata[17:7] == '0)
    else $error("out of range key reported state");

endmodule

bind analog_key_rapid_trigger_core akrt_chk #(
  .KEY_COUNT  (KEY_COUNT),
  .TRAVEL_MAX (TRAVEL_MAX)
) u_akrt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import akrt_pkg::*;

  localparam int unsigned KEYS = 128;
  localparam int unsigned FULL = 240;
  localparam int unsigned DEF_REST = 3000;
  localparam int unsigned DEF_BOT = 2000;
  localparam int unsigned SETTLE = 100;
  localparam int unsigned WATCHDOG = 20000;

  typedef struct packed {
    logic       calibrated;
    logic       changed;
    logic       key_down;
    logic [7:0] travel;
    logic [6:0] key;
  } key_result_t;

  // travel and trigger predictor with its own per-key state
  class key_scoreboard;
    logic [0:0]  mode;
    logic [7:0]  act, hyst, sens, zone;
    logic [11:0] zjit, fjit;
    logic [15:0] settle;
    phase_e      phase [KEYS];
    logic [8:0]  press_pt [KEYS];
    logic [7:0]  rel_pt [KEYS];
    logic        cal [KEYS], stab [KEYS], bot [KEYS];
    logic [31:0] stab_t [KEYS], bot_t [KEYS];
    logic [11:0] prev [KEYS], rest_lv [KEYS], bot_lv [KEYS];
    key_result_t pending [$];
    int          errors;

    function new();
      mode = 0; act = 120; hyst = 30; sens = 18;
      zjit = 50; fjit = 100; settle = 500; zone = 228;
      errors = 0;
      for (int k = 0; k < KEYS; k++) begin
        phase[k] = PH_REG_REL; press_pt[k] = 0; rel_pt[k] = 0;
        cal[k] = 0; stab[k] = 0; bot[k] = 0; prev[k] = 0;
        rest_lv[k] = DEF_REST; bot_lv[k] = DEF_BOT;
      end
    endfunction

    function void write_reg(cfg_index_e idx, logic [15:0] v);
      case (idx)
        CFG_KEY_MODE:       mode = v[0];
        CFG_ACTUATION:      act = v[7:0];
        CFG_HYSTERESIS:     hyst = v[7:0];
        CFG_SENSITIVITY:    sens = v[7:0];
        CFG_ZERO_JITTER:    zjit = v[11:0];
        CFG_FULL_JITTER:    fjit = v[11:0];
        CFG_RELEASE_SETTLE: settle = v;
        CFG_BOTTOM_ZONE:    zone = v[7:0];
        default:            ;
      endcase
    endfunction

    function int unsigned adiff(int unsigned a, int unsigned b);
      return a > b ? a - b : b - a;
    endfunction

    function void follow_press(int k, int unsigned t);
      rel_pt[k] = t > sens ? 8'(t - sens) : 8'd0;
      press_pt[k] = 9'(t);
    endfunction

    function void follow_release(int k, int unsigned t);
      rel_pt[k] = 8'(t);
      press_pt[k] = 9'(t + sens);
    endfunction

    // note one accepted sample
    function void sample_in(logic [6:0] key, logic [11:0] raw, logic [31:0] now);
      int unsigned top, btm, r, t, rl;
      logic chg;
      key_result_t e;
      int k;
      k = key;
      e = '0;
      e.key = key;
      top = cal[k] ? rest_lv[k] : DEF_REST;
      btm = cal[k] ? bot_lv[k] : DEF_BOT;
      r = raw;
      t = 0;
      if (btm < top) begin
        if (r > top) r = top;
        if (r < btm) r = btm;
        t = ((top - r) * FULL) / (top - btm);
        if (t > FULL) t = FULL;
      end
      // calibration
      if (adiff(raw, prev[k]) < zjit) begin
        if (!stab[k]) begin stab[k] = 1; stab_t[k] = now; end
      end else begin
        stab[k] = 0;
      end
      if (stab[k] && !bot[k] && (now - stab_t[k]) > settle)
        if (!cal[k] || adiff(raw, rest_lv[k]) > zjit) rest_lv[k] = raw;
      if (t + 10 > zone) begin
        if (!bot[k]) begin bot[k] = 1; bot_t[k] = now; end
        if ((now - bot_t[k]) > SETTLE && stab[k])
          if (!cal[k] || adiff(raw, bot_lv[k]) > fjit) begin
            bot_lv[k] = raw; cal[k] = 1;
          end
      end else begin
        bot[k] = 0;
      end
      prev[k] = raw;
      // phase machine
      rl = act > hyst ? act - hyst : 0;
      chg = 0;
      if (phase[k] == PH_REG_REL) begin
        if (t >= act) begin
          phase[k] = PH_REG_PRS; chg = 1;
          if (mode) follow_press(k, t);
        end
      end else if (!mode) begin
        if (phase[k] == PH_REG_PRS && t <= rl) begin phase[k] = PH_REG_REL; chg = 1; end
      end else if (phase[k] == PH_RPD_REL) begin
        if (t <= rl) phase[k] = PH_REG_REL;
        else if (t >= press_pt[k] && t >= act) begin
          phase[k] = PH_RPD_PRS; chg = 1; follow_press(k, t);
        end else if (t < rel_pt[k]) follow_release(k, t);
      end else begin
        if (t <= rl) begin phase[k] = PH_REG_REL; chg = 1; end
        else if (t <= rel_pt[k] && t + sens < zone) begin
          phase[k] = PH_RPD_REL; chg = 1; follow_release(k, t);
        end else if (t > press_pt[k]) follow_press(k, t);
      end
      e.travel = 8'(t);
      e.key_down = (phase[k] == PH_REG_PRS) || (phase[k] == PH_RPD_PRS);
      e.changed = chg;
      e.calibrated = cal[k];
      pending.push_back(e);
    endfunction

    // compare one result transfer
    function void check(key_result_t got);
      key_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch key %0d: exp trv %0d dn %b ch %b cal %b, ",
                    "got key %0d trv %0d dn %b ch %b cal %b"},
                   e.key, e.travel, e.key_down, e.changed, e.calibrated,
                   got.key, got.travel, got.key_down, got.changed, got.calibrated);
      end
    endfunction
  endclass

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 0;
  logic                  cfg_ready_o;
  logic [2:0]            cfg_addr_i = '0;
  logic [15:0]           cfg_data_i = '0;

  key_scoreboard sb = new();
  int  idle_pct = 29;
  int  quiet = 0;
  logic [31:0] clock_ms = 0;

  analog_key_rapid_trigger_core i_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // result side: random stalls, check each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check(key_result_t'(m_axis_tdata[17:0]));
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // valid stays up across back-to-back samples and drops only when idling
  task automatic send_sample(logic [6:0] key, logic [11:0] raw, logic [31:0] now);
    // close any configuration burst
    cfg_valid_i <= 0;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {5'b0, now, raw, key};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.sample_in(key, raw, now);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [15:0] v);
    cfg_valid_i <= 1;
    cfg_addr_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, v);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // one press and release stroke on a key, random depth and noise
  task automatic stroke(logic [6:0] key);
    int unsigned depth, lvl, steps;
    depth = $urandom_range(1900, 400);
    steps = $urandom_range(12, 3);
    for (int i = 0; i < 2 * steps; i++) begin
      lvl = i < steps ? 3050 - depth * i / (steps - 1) :
                        3050 - depth * (2 * steps - 1 - i) / steps;
      if ($urandom_range(5) == 0) lvl += $urandom_range(60);
      clock_ms += $urandom_range(150);
      send_sample(key, 12'(lvl > 4095 ? 4095 : lvl), clock_ms);
    end
  endtask

  initial begin
    int phase_n;
    logic [6:0] k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: field extremes and the special cases
    send_sample(7'd0, 12'd0, 32'd0);
    send_sample(7'd127, 12'hfff, 32'hffff_ffff);
    send_sample(7'd0, 12'd3000, 32'd5);
    send_sample(7'd0, 12'd2000, 32'd10);
    send_sample(7'd0, 12'd2000, 32'd200);
    send_sample(7'd0, 12'd2000, 32'd400);
    send_sample(7'd0, 12'd3000, 32'd500);
    send_sample(7'd1, 12'h555, 32'haaaa_aaaa);
    send_sample(7'd1, 12'haaa, 32'h5555_5555);
    drain();
    // reversed levels: learn a bottom at the top of the range on key 2
    write_reg(CFG_BOTTOM_ZONE, 16'd10);
    write_reg(CFG_ZERO_JITTER, 16'd4095);
    write_reg(CFG_FULL_JITTER, 16'd0);
    for (int i = 0; i < 4; i++) send_sample(7'd2, 12'd2990, 32'd1000 + 200 * i);
    send_sample(7'd2, 12'd100, 32'd2000);
    send_sample(7'd2, 12'd4095, 32'd2300);
    drain();
    // rapid mode then back to static with rapid phases held
    write_reg(CFG_KEY_MODE, 16'd1);
    write_reg(CFG_BOTTOM_ZONE, 16'd250);
    write_reg(CFG_ZERO_JITTER, 16'd0);
    send_sample(7'd3, 12'd2200, 32'd10);
    send_sample(7'd3, 12'd2500, 32'd20);
    send_sample(7'd3, 12'd2100, 32'd30);
    send_sample(7'd3, 12'd2700, 32'd40);
    drain();
    write_reg(CFG_KEY_MODE, 16'd0);
    send_sample(7'd3, 12'd2300, 32'd50);
    send_sample(7'd3, 12'd3000, 32'd60);
    drain();

    // random phases across settings, extremes included
    for (phase_n = 0; phase_n < 10; phase_n++) begin
      idle_pct = (phase_n == 4) ? 0 : 29;
      write_reg(CFG_KEY_MODE, 16'(phase_n[0]));
      write_reg(CFG_ACTUATION, 16'(phase_n == 1 ? 1 : phase_n == 2 ? 240 :
                                   $urandom_range(200, 30)));
      write_reg(CFG_HYSTERESIS, 16'(phase_n == 2 ? 240 : phase_n == 3 ? 0 :
                                    $urandom_range(60)));
      write_reg(CFG_SENSITIVITY, 16'(phase_n == 1 ? 1 : phase_n == 3 ? 240 :
                                     $urandom_range(40, 2)));
      write_reg(CFG_ZERO_JITTER, 16'(phase_n == 5 ? 4095 : phase_n == 6 ? 0 :
                                     $urandom_range(100)));
      write_reg(CFG_FULL_JITTER, 16'(phase_n == 5 ? 4095 : phase_n == 6 ? 0 :
                                     $urandom_range(200)));
      write_reg(CFG_RELEASE_SETTLE, 16'(phase_n == 7 ? 65535 : phase_n == 6 ? 0 :
                                        $urandom_range(600)));
      write_reg(CFG_BOTTOM_ZONE, 16'(phase_n == 8 ? 10 : phase_n == 9 ? 250 :
                                     $urandom_range(240, 150)));
      for (int s = 0; s < 6; s++) begin
        k = 7'($urandom_range(7));
        if ($urandom_range(3) == 0) k = 7'($urandom());
        stroke(k);
      end
      for (int s = 0; s < 17; s++) begin
        clock_ms += $urandom();
        send_sample(7'($urandom()), 12'($urandom()),
                    $urandom_range(3) == 0 ? $urandom() : clock_ms);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
